// File: hdl/inbb_pkg.sv
`default_nettype none
package inbb_pkg;

    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_MOVE      = 3'd1,
        OP_RECOMPUTE = 3'd2,
        OP_COMMIT    = 3'd3,
        OP_RESET     = 3'd4
    } t_op;

    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_OUTWARD = 2'd1;
    localparam logic [1:0] CLS_INWARD  = 2'd2;
    localparam logic [1:0] CLS_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [9:0] net_index;
        logic       axis;
        logic [9:0] load_low;
        logic [9:0] load_high;
        logic [9:0] load_low_count;
        logic [9:0] load_high_count;
        logic [9:0] old_pos;
        logic [9:0] new_pos;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] change_class;
        logic       newly_listed;
        logic [9:0] work_low;
        logic [9:0] work_high;
        logic [9:0] work_low_count;
        logic [9:0] work_high_count;
    } t_out_beat;

    // classified item handed from front to back
    typedef struct packed {
        logic       in_range;
        logic [2:0] op;
        logic [10:0] entry;
        logic [9:0] load_low;
        logic [9:0] load_high;
        logic [9:0] load_low_count;
        logic [9:0] load_high_count;
        logic [9:0] old_pos;
        logic [9:0] new_pos;
    } t_cmd;

endpackage
`default_nettype wire

// File: hdl/incremental_net_bbox_update.sv
// an input beat passes through the queue, then the command register and ram read, then the
// output register; beats still ahead in the back or the queue, or an output stall, delay it
// the back takes no new item while it reads then writes the entry rams
// the front queue holds two beats so input stays open while the back works
// reset clears queue and pipeline valids, then a pass writes all 2*NET_COUNT working
// entries with class none; beats wait in the queue until it ends
`default_nettype none
module incremental_net_bbox_update #(
    parameter int NET_COUNT  = 1024,
    parameter int COORD_BITS = 10,
    parameter int COUNT_BITS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire inbb_pkg::t_in_beat  i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output inbb_pkg::t_out_beat      o_data
);
    logic w_cmd_valid, w_cmd_pop;
    inbb_pkg::t_cmd w_cmd;

    inbb_front #(.NET_COUNT(NET_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_cmd_valid(w_cmd_valid), .i_cmd_pop(w_cmd_pop),
        .o_cmd(w_cmd)
    );

    inbb_back #(.NET_COUNT(NET_COUNT), .COORD_BITS(COORD_BITS),
                .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .o_cmd_pop(w_cmd_pop), .i_cmd(w_cmd), .o_valid(o_valid),
        .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

// File: hdl/inbb_ram.sv
`default_nettype none
module inbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hdl/inbb_front.sv
`default_nettype none
module inbb_front #(
    parameter int NET_COUNT = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire inbb_pkg::t_in_beat i_data,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_pop,
    output inbb_pkg::t_cmd         o_cmd
);
    // two-entry queue
    inbb_pkg::t_cmd r_q [2];
    logic [0:0] r_rd, r_wr;
    logic [1:0] r_cnt;
    inbb_pkg::t_cmd w_cmd;
    logic w_push;

    always_comb begin
        w_cmd.in_range        = ({22'd0, i_data.net_index} < NET_COUNT);
        w_cmd.op              = i_data.op;
        w_cmd.entry           = {i_data.net_index, i_data.axis};
        w_cmd.load_low        = i_data.load_low;
        w_cmd.load_high       = i_data.load_high;
        w_cmd.load_low_count  = i_data.load_low_count;
        w_cmd.load_high_count = i_data.load_high_count;
        w_cmd.old_pos         = i_data.old_pos;
        w_cmd.new_pos         = i_data.new_pos;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (i_cmd_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end
endmodule
`default_nettype wire

// File: hdl/inbb_back.sv
`default_nettype none
module inbb_back #(
    parameter int NET_COUNT  = 1024,
    parameter int COORD_BITS = 10,
    parameter int COUNT_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_pop,
    input  wire inbb_pkg::t_cmd     i_cmd,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output inbb_pkg::t_out_beat     o_data
);
    localparam int ENTRIES = 2 * NET_COUNT;
    localparam int AW = $clog2(ENTRIES);
    localparam int BW = 2 * COORD_BITS + 2 * COUNT_BITS;
    localparam int CW = 2 * COORD_BITS + 2 * COUNT_BITS + 2;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // sequence: read, then modify and write
    logic r_busy;
    inbb_pkg::t_cmd r_cmd;
    logic [CW-1:0] w_wrd, w_wwd, w_rd_w;
    logic [BW-1:0] w_crd, w_cwd;
    logic w_we_w, w_we_c;
    logic [AW-1:0] w_raddr, w_addr;
    logic r_out_v;
    inbb_pkg::t_out_beat r_out;

    // clearing pass over the working ram after reset
    logic r_clr;
    logic [AW-1:0] r_clr_addr;
    logic w_we_ram;
    logic [AW-1:0] w_waddr_w;
    logic [CW-1:0] w_wdata_w;

    logic [COORD_BITS-1:0] lo, hi, op_o, op_n;
    logic [COUNT_BITS-1:0] nlo, nhi;
    logic [1:0] cls;
    logic listed;
    inbb_pkg::t_out_beat w_res;

    assign w_raddr   = AW'(i_cmd.entry);
    assign w_addr    = AW'(r_cmd.entry);
    assign o_cmd_pop = i_cmd_valid && !r_busy && !r_clr && !(r_out_v && i_stall);
    assign o_valid   = r_out_v;
    assign o_data    = r_out;

    assign w_we_ram  = r_clr || w_we_w;
    assign w_waddr_w = r_clr ? r_clr_addr : w_addr;
    assign w_wdata_w = r_clr ? '0 : w_wwd;

    inbb_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_work (
        .i_clk(i_clk), .i_we(w_we_ram), .i_waddr(w_waddr_w), .i_wdata(w_wdata_w),
        .i_raddr(w_raddr), .o_rdata(w_rd_w)
    );
    inbb_ram #(.WIDTH(BW), .DEPTH(ENTRIES)) u_comm (
        .i_clk(i_clk), .i_we(w_we_c), .i_waddr(w_addr), .i_wdata(w_cwd),
        .i_raddr(w_raddr), .o_rdata(w_crd)
    );

    assign w_wrd = w_rd_w;

    always_comb begin
        {lo, hi, nlo, nhi, cls} = w_wrd;
        op_o   = COORD_BITS'(r_cmd.old_pos);
        op_n   = COORD_BITS'(r_cmd.new_pos);
        listed = 1'b0;
        w_we_w = 1'b0;
        w_we_c = 1'b0;
        w_cwd  = {lo, hi, nlo, nhi};
        case (r_cmd.op)
            inbb_pkg::OP_LOAD: begin
                lo  = COORD_BITS'(r_cmd.load_low);
                hi  = COORD_BITS'(r_cmd.load_high);
                nlo = COUNT_BITS'(r_cmd.load_low_count);
                nhi = COUNT_BITS'(r_cmd.load_high_count);
                cls = inbb_pkg::CLS_NONE;
                w_cwd = {lo, hi, nlo, nhi};
                w_we_w = 1'b1;
                w_we_c = 1'b1;
            end
            inbb_pkg::OP_MOVE: begin
                if (op_n < lo) begin
                    lo = op_n; nlo = COUNT_BITS'(1);
                    if (cls == inbb_pkg::CLS_NONE) begin
                        cls = inbb_pkg::CLS_OUTWARD; listed = 1'b1;
                    end
                end else if (op_n == lo && op_o > lo) begin
                    if (nlo != CNT_MAX) nlo = nlo + 1'b1;
                    if (cls == inbb_pkg::CLS_NONE) begin
                        cls = inbb_pkg::CLS_OUTWARD; listed = 1'b1;
                    end
                end else if (op_o == lo && op_n > lo) begin
                    if (cls == inbb_pkg::CLS_NONE) listed = 1'b1;
                    if (nlo <= 1) cls = inbb_pkg::CLS_FULL;
                    else begin
                        nlo = nlo - 1'b1;
                        if (cls == inbb_pkg::CLS_NONE) cls = inbb_pkg::CLS_INWARD;
                    end
                end
                if (op_n > hi) begin
                    hi = op_n; nhi = COUNT_BITS'(1);
                    if (cls == inbb_pkg::CLS_NONE) begin
                        cls = inbb_pkg::CLS_OUTWARD; listed = 1'b1;
                    end
                end else if (op_n == hi && op_o < hi) begin
                    if (nhi != CNT_MAX) nhi = nhi + 1'b1;
                    if (cls == inbb_pkg::CLS_NONE) begin
                        cls = inbb_pkg::CLS_OUTWARD; listed = 1'b1;
                    end
                end else if (op_o == hi && op_n < hi) begin
                    if (cls == inbb_pkg::CLS_NONE) listed = 1'b1;
                    if (nhi <= 1) cls = inbb_pkg::CLS_FULL;
                    else begin
                        nhi = nhi - 1'b1;
                        if (cls == inbb_pkg::CLS_NONE) cls = inbb_pkg::CLS_INWARD;
                    end
                end
                w_we_w = 1'b1;
            end
            inbb_pkg::OP_RECOMPUTE: begin
                lo  = COORD_BITS'(r_cmd.load_low);
                hi  = COORD_BITS'(r_cmd.load_high);
                nlo = COUNT_BITS'(r_cmd.load_low_count);
                nhi = COUNT_BITS'(r_cmd.load_high_count);
                w_we_w = 1'b1;
            end
            inbb_pkg::OP_COMMIT: begin
                w_we_c = 1'b1;
            end
            inbb_pkg::OP_RESET: begin
                {lo, hi, nlo, nhi} = w_crd;
                cls = inbb_pkg::CLS_NONE;
                w_we_w = 1'b1;
            end
            default: begin
            end
        endcase
        if (!r_cmd.in_range || !r_busy) begin
            w_we_w = 1'b0;
            w_we_c = 1'b0;
        end
        w_wwd = {lo, hi, nlo, nhi, cls};
        w_res.change_class    = cls;
        w_res.newly_listed    = listed;
        w_res.work_low        = 10'(lo);
        w_res.work_high       = 10'(hi);
        w_res.work_low_count  = 10'(nlo);
        w_res.work_high_count = 10'(nhi);
        if (!r_cmd.in_range) w_res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) r_cmd <= i_cmd;
        if (r_busy) r_out <= w_res;
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_v    <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy <= o_cmd_pop;
            if (r_busy) r_out_v <= 1'b1;
            else if (!i_stall) r_out_v <= 1'b0;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(ENTRIES - 1)) r_clr <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
